// ===== rtl/sgm_pkg.sv =====
// ----------------------------------------------------------------------------
// sgm_pkg: shared types and constants for the Sobel gradient magnitude block
// Sizes, kernel coefficients, register codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package sgm_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int PIX_W  = 8;
	localparam int DIM_W  = 11;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT + 4);
	localparam int CMP_W  = DIM_W + 2;
	localparam int GRAD_W = 11;
	localparam int SQ_W   = 20;
	localparam int RAD_W  = SQ_W + 1;
	localparam int MAG_W  = 11;
	localparam int MAG_MAX = 1442;
	localparam int ROOT_TOP = 2 * ((RAD_W - 1) / 2);

	localparam int WIDTH_RESET  = 1024;
	localparam int HEIGHT_RESET = 1024;

	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_index_t;

	typedef logic signed [2:0] kern_t [3][3];

	// [row: top, middle, bottom][column: left, center, right]
	localparam kern_t KERN_X = '{
		'{-3'sd1, 3'sd0, 3'sd1},
		'{-3'sd2, 3'sd0, 3'sd2},
		'{-3'sd1, 3'sd0, 3'sd1}
	};
	localparam kern_t KERN_Y = '{
		'{-3'sd1, -3'sd2, -3'sd1},
		'{ 3'sd0,  3'sd0,  3'sd0},
		'{ 3'sd1,  3'sd2,  3'sd1}
	};

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_CONV,
		S_SQUARE,
		S_ROOT_INIT,
		S_ROOT
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic conv;
		logic square;
		logic root_init;
		logic root_step;
		logic publish;
	} sgm_cmd_t;

	typedef struct packed {
		logic emit;
		logic root_busy;
		logic out_free;
	} sgm_status_t;

endpackage

// ===== rtl/sgm_pixel_if.sv =====
// ----------------------------------------------------------------------------
// sgm_pixel_if: input pixel channel
// Valid/ready channel carrying one grayscale pixel word.
// ----------------------------------------------------------------------------
interface sgm_pixel_if;
	logic                        valid;
	logic                        ready;
	logic [sgm_pkg::PIX_W-1:0]   pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

// ===== rtl/sgm_result_if.sv =====
// ----------------------------------------------------------------------------
// sgm_result_if: gradient result channel
// Valid/ready channel carrying one magnitude word and its end-of-frame flag.
// ----------------------------------------------------------------------------
interface sgm_result_if;
	logic                        valid;
	logic                        ready;
	logic [sgm_pkg::MAG_W-1:0]   gradient_magnitude;
	logic                        frame_last;

	modport source (output valid, output gradient_magnitude, output frame_last, input ready);
	modport sink   (input valid, input gradient_magnitude, input frame_last, output ready);
endinterface

// ===== rtl/sobel_gradient_magnitude_3x3.sv =====
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_3x3: streaming 3x3 Sobel gradient magnitude
// Takes raster-order grayscale pixels and returns floor(sqrt(gx^2 + gy^2))
// per position, with pixels outside the image counted as zero.
// ----------------------------------------------------------------------------
//
//   channel      direction  word
//   -----------  ---------  -------------------------------------------------
//   pixel_in     in         pixel[7:0]
//   result_out   out        gradient_magnitude[10:0], frame_last
//   cfg_*        in         cfg_index selects image_width or image_height
//
// A word that yields no result passes through lookup, window update and
// kernel sums; one that yields a result goes on to squares, root setup, 11
// steps of the square-root unit, which set the pace, and the load of the
// output register.
// Results lag their pixel by image_width+1 words; send that many trailing
// flush words after the last pixel of a frame.
// Reset clears counters, window, controller and output valid; the line
// stores hold garbage until written and need no clearing pass.
// A stalled result waits in the output register; the next pixel word is
// still taken, and only a second result waits for the first to drain.
//
module sobel_gradient_magnitude_3x3 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sgm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sgm_pkg::DIM_W-1:0]     cfg_wdata,
	sgm_pixel_if.sink                     pixel_in,
	sgm_result_if.source                  result_out
);
	import sgm_pkg::*;

	logic [DIM_W-1:0] width_cfg_q;
	logic [DIM_W-1:0] height_cfg_q;
	logic [DIM_W-1:0] img_w;
	logic [DIM_W-1:0] img_h;
	sgm_cmd_t         cmd;
	sgm_status_t      status;

	// configuration registers; the user must write them only while no word is in flight (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_cfg_q  <= DIM_W'(WIDTH_RESET);
			height_cfg_q <= DIM_W'(HEIGHT_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_IMAGE_WIDTH:  width_cfg_q  <= cfg_wdata;
				CFG_IMAGE_HEIGHT: height_cfg_q <= cfg_wdata;
			endcase
		end
	end

	// treat zero as one and saturate oversize values to the store depth
	always_comb begin
		if (width_cfg_q == '0) begin
			img_w = DIM_W'(1);
		end else if (width_cfg_q > DIM_W'(MAX_WIDTH)) begin
			img_w = DIM_W'(MAX_WIDTH);
		end else begin
			img_w = width_cfg_q;
		end
		if (height_cfg_q == '0) begin
			img_h = DIM_W'(1);
		end else if (height_cfg_q > DIM_W'(MAX_HEIGHT)) begin
			img_h = DIM_W'(MAX_HEIGHT);
		end else begin
			img_h = height_cfg_q;
		end
	end

	// sequence each pixel word through the datapath
	sgm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixel_in.valid),
		.in_ready (pixel_in.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// line stores, window, kernels, root and output register
	sgm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.img_w     (img_w),
		.img_h     (img_h),
		.in_pixel  (pixel_in.pixel),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.out_mag   (result_out.gradient_magnitude),
		.out_last  (result_out.frame_last)
	);
endmodule

// ===== rtl/sgm_ram.sv =====
// ----------------------------------------------------------------------------
// sgm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sgm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/sgm_ctrl.sv =====
// ----------------------------------------------------------------------------
// sgm_ctrl: controller for the Sobel gradient magnitude block
// Steps one pixel word through line-store access, convolution, squaring and
// the iterative square root, and hands the result to the output register.
// ----------------------------------------------------------------------------
module sgm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sgm_pkg::sgm_status_t status,
	output sgm_pkg::sgm_cmd_t    cmd
);
	import sgm_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_LOAD;
			end
			S_LOAD:      state_d = S_CONV;
			S_CONV: begin
				state_d = status.emit ? S_SQUARE : S_IDLE;
			end
			S_SQUARE:    state_d = S_ROOT_INIT;
			S_ROOT_INIT: state_d = S_ROOT;
			S_ROOT: begin
				if (!status.root_busy && status.out_free) state_d = S_IDLE;
			end
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			S_LOAD:      cmd.load = 1'b1;
			S_CONV:      cmd.conv = 1'b1;
			S_SQUARE:    cmd.square = 1'b1;
			S_ROOT_INIT: cmd.root_init = 1'b1;
			S_ROOT: begin
				cmd.root_step = status.root_busy;
				cmd.publish   = !status.root_busy && status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end
endmodule

// ===== rtl/sgm_datapath.sv =====
// ----------------------------------------------------------------------------
// sgm_datapath: datapath for the Sobel gradient magnitude block
// Position counters, two line stores, the 3x3 window, border masking, kernel
// sums, squares, a radix-2 restoring square root and the output register.
// ----------------------------------------------------------------------------
module sgm_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sgm_pkg::sgm_cmd_t           cmd,
	output sgm_pkg::sgm_status_t        status,
	input  logic [sgm_pkg::DIM_W-1:0]   img_w,
	input  logic [sgm_pkg::DIM_W-1:0]   img_h,
	input  logic [sgm_pkg::PIX_W-1:0]   in_pixel,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sgm_pkg::MAG_W-1:0]   out_mag,
	output logic                        out_last
);
	import sgm_pkg::*;

	// position counters
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             wrap_in;
	logic [COL_W-1:0] ci;
	logic [ROW_W-1:0] ri;
	logic [CMP_W-1:0] col_inc;
	logic             wrap_out;
	logic [COL_W-1:0] col_next;
	logic [ROW_W-1:0] row_adv;
	logic             restart;

	// window and line stores
	logic [PIX_W-1:0] pixel_q;
	logic [PIX_W-1:0] win_q [3][3];
	logic [PIX_W-1:0] upper_rd;
	logic [PIX_W-1:0] middle_rd;

	// output position of the current word
	logic signed [ROW_W:0] orow_d;
	logic [COL_W-1:0]      ocol_d;
	logic signed [ROW_W:0] orow_q;
	logic [COL_W-1:0]      ocol_q;

	// convolution
	logic [2:0]               row_ok;
	logic [2:0]               col_ok;
	logic signed [GRAD_W-1:0] gx_sum;
	logic signed [GRAD_W-1:0] gy_sum;
	logic                     emit;
	logic                     last_now;
	logic signed [GRAD_W-1:0] gx_q;
	logic signed [GRAD_W-1:0] gy_q;
	logic                     last_q;

	// squares and root
	logic signed [2*GRAD_W-1:0] sqx_full;
	logic signed [2*GRAD_W-1:0] sqy_full;
	logic [SQ_W-1:0]            sqx_q;
	logic [SQ_W-1:0]            sqy_q;
	logic [RAD_W-1:0]           rad_q;
	logic [RAD_W-1:0]           res_q;
	logic [RAD_W-1:0]           bit_q;
	logic [RAD_W:0]             trial;
	logic                       fits;

	// output register
	logic             out_valid_q;
	logic [MAG_W-1:0] mag_q;
	logic             frame_last_q;

	// wrap a column left out of range by a narrower width
	always_comb begin
		wrap_in = CMP_W'(col_q) >= CMP_W'(img_w);
		ci      = wrap_in ? '0 : col_q;
		ri      = wrap_in ? row_q + ROW_W'(1) : row_q;
	end

	always_comb begin
		col_inc  = CMP_W'(col_q) + CMP_W'(1);
		wrap_out = col_inc >= CMP_W'(img_w);
		col_next = wrap_out ? '0 : col_inc[COL_W-1:0];
		row_adv  = wrap_out ? row_q + ROW_W'(1) : row_q;
		restart  = last_now || (CMP_W'(row_adv) > CMP_W'(img_h) + CMP_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.accept) begin
			col_q <= ci;
			row_q <= ri;
		end else if (cmd.conv) begin
			if (restart) begin
				col_q <= '0;
				row_q <= '0;
			end else begin
				col_q <= col_next;
				row_q <= row_adv;
			end
		end
	end

	sgm_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_upper (
		.clk   (clk),
		.we    (cmd.load),
		.waddr (col_q),
		.wdata (middle_rd),
		.raddr (ci),
		.rdata (upper_rd)
	);

	sgm_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_middle (
		.clk   (clk),
		.we    (cmd.load),
		.waddr (col_q),
		.wdata (pixel_q),
		.raddr (ci),
		.rdata (middle_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pixel_q <= in_pixel;
		end
	end

	// the window center sits one column and one row behind the input
	always_comb begin
		orow_d = $signed((ROW_W+1)'(row_q))
			- ((col_q != '0) ? (ROW_W+1)'(1) : (ROW_W+1)'(2));
		ocol_d = (col_q != '0) ? col_q - COL_W'(1) : COL_W'(img_w - DIM_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (cmd.load) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= upper_rd;
			win_q[1][2] <= middle_rd;
			win_q[2][2] <= pixel_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			orow_q <= orow_d;
			ocol_q <= ocol_d;
		end
	end

	// mask taps outside the image and apply both kernels
	always_comb begin
		logic signed [CMP_W-1:0]  yy;
		logic signed [CMP_W-1:0]  xx;
		logic signed [GRAD_W-1:0] tap;
		for (int r = 0; r < 3; r++) begin
			yy = CMP_W'(orow_q) + CMP_W'(r) - CMP_W'(1);
			row_ok[r] = !yy[CMP_W-1] && ($unsigned(yy) < CMP_W'(img_h));
		end
		for (int c = 0; c < 3; c++) begin
			xx = CMP_W'(ocol_q) + CMP_W'(c) - CMP_W'(1);
			col_ok[c] = !xx[CMP_W-1] && ($unsigned(xx) < CMP_W'(img_w));
		end
		gx_sum = '0;
		gy_sum = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				tap = (row_ok[r] && col_ok[c]) ? GRAD_W'(win_q[r][c]) : '0;
				gx_sum = gx_sum + KERN_X[r][c] * tap;
				gy_sum = gy_sum + KERN_Y[r][c] * tap;
			end
		end
	end

	always_comb begin
		emit     = !orow_q[ROW_W] && (CMP_W'(orow_q[ROW_W-1:0]) < CMP_W'(img_h));
		last_now = (CMP_W'(orow_q) == CMP_W'(img_h) - CMP_W'(1))
			&& (CMP_W'(ocol_q) == CMP_W'(img_w) - CMP_W'(1));
	end

	always_ff @(posedge clk) begin
		if (cmd.conv) begin
			gx_q   <= gx_sum;
			gy_q   <= gy_sum;
			last_q <= last_now;
		end
	end

	assign sqx_full = gx_q * gx_q;
	assign sqy_full = gy_q * gy_q;

	always_ff @(posedge clk) begin
		if (cmd.square) begin
			sqx_q <= sqx_full[SQ_W-1:0];
			sqy_q <= sqy_full[SQ_W-1:0];
		end
	end

	// one result bit per step, from the top even power of two down
	always_comb begin
		trial = (RAD_W+1)'(res_q) + (RAD_W+1)'(bit_q);
		fits  = (RAD_W+1)'(rad_q) >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (cmd.root_init) begin
			bit_q <= RAD_W'(1) << ROOT_TOP;
		end else if (cmd.root_step) begin
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.root_init) begin
			rad_q <= RAD_W'(sqx_q) + RAD_W'(sqy_q);
			res_q <= '0;
		end else if (cmd.root_step) begin
			if (fits) begin
				rad_q <= rad_q - trial[RAD_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			mag_q        <= res_q[MAG_W-1:0];
			frame_last_q <= last_q;
		end
	end

	assign status.emit      = emit;
	assign status.root_busy = bit_q != '0;
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_mag   = mag_q;
	assign out_last  = frame_last_q;
endmodule

// ===== rtl/sgm_checker.sv =====
// ----------------------------------------------------------------------------
// sgm_checker: port-level checks for the Sobel gradient magnitude block
// Watches the pixel and result channels and flags timing or range slips.
// ----------------------------------------------------------------------------
module sgm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [sgm_pkg::MAG_W-1:0]   gradient_magnitude,
	input logic                        frame_last
);
	import sgm_pkg::*;

	// a result word held back by the sink must not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(gradient_magnitude)
			&& $stable(frame_last))
		else $error("result word changed while stalled");

	// one pixel word at a time: ready drops right after an accept
	a_single_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second pixel word taken while one is in flight");

	// a result needs the full root sequence, never the next cycle
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared right after a pixel accept");

	// magnitude can never exceed the diagonal of the largest gradients
	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> gradient_magnitude <= MAG_W'(MAG_MAX))
		else $error("gradient magnitude out of range");
endmodule

bind sobel_gradient_magnitude_3x3 sgm_checker u_sgm_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (pixel_in.valid),
	.in_ready           (pixel_in.ready),
	.out_valid          (result_out.valid),
	.out_ready          (result_out.ready),
	.gradient_magnitude (result_out.gradient_magnitude),
	.frame_last         (result_out.frame_last)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sobel_gradient_magnitude_3x3
// Streams raster frames of many sizes into the pixel channel and predicts
// every gradient word from a software copy of the line stores, window and
// counters. Both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
	import sgm_pkg::*;

	// Cycles to let a result-less word clear the block before a register write.
	localparam int IDLE_CYCLES  = 24;
	localparam int RANDOM_WORDS = 300;

	typedef struct packed {
		logic [MAG_W-1:0] magnitude;
		logic             frame_last;
	} gradient_t;

	typedef enum int {
		PIX_RANDOM,
		PIX_FULL,
		PIX_DIAGONAL,
		PIX_CHECKER,
		PIX_EXTREME,
		PIX_SMOOTH
	} pixel_style_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_wdata;

	sgm_pixel_if  pixel_ch ();
	sgm_result_if result_ch ();

	sobel_gradient_magnitude_3x3 dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.pixel_in   (pixel_ch),
		.result_out (result_ch)
	);

	// Software image of the block: two line stores, the 3x3 window
	// ([row: top, middle, bottom][column: left, center, right]), the raster
	// counters and the two size registers as last written.
	logic [PIX_W-1:0] upper_line  [MAX_WIDTH];
	logic [PIX_W-1:0] middle_line [MAX_WIDTH];
	logic [PIX_W-1:0] window_px   [3][3];
	int unsigned      in_col;
	int unsigned      in_row;
	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;

	// Gradient words owed by the block, oldest first.
	gradient_t expected_gradients [$];

	int errors;
	int words_sent;
	int burst_left;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#6000000;
		$display("testbench failed");
		$finish;
	end

	// Zero and oversize register values collapse to the legal range.
	function automatic int unsigned clamp_size(logic [DIM_W-1:0] v, int unsigned limit);
		if (v == '0)
			return 1;
		if (v > limit)
			return limit;
		return v;
	endfunction

	function automatic logic [MAG_W-1:0] floor_root(int unsigned v);
		int unsigned root;
		int unsigned trial;
		root = 0;
		for (int b = MAG_W - 1; b >= 0; b--) begin
			trial = root | (32'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root[MAG_W-1:0];
	endfunction

	// Advance the software image by one accepted pixel word and queue the
	// gradient word it releases, if any. The output position trails the input
	// by one column, so column 0 closes the last column of the row before.
	function automatic void predict_pixel(logic [PIX_W-1:0] value);
		int unsigned w;
		int unsigned h;
		int unsigned ci;
		int unsigned ri;
		int          orow;
		int          ocol;
		int          yy;
		int          xx;
		int          gx;
		int          gy;
		int          p [3][3];
		logic        frame_end;
		w = clamp_size(width_reg, MAX_WIDTH);
		h = clamp_size(height_reg, MAX_HEIGHT);
		frame_end = 1'b0;
		// a column left beyond a narrowed width wraps to the next row
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		ci = in_col;
		ri = in_row;
		for (int r = 0; r < 3; r++) begin
			window_px[r][0] = window_px[r][1];
			window_px[r][1] = window_px[r][2];
		end
		window_px[0][2] = upper_line[ci];
		window_px[1][2] = middle_line[ci];
		window_px[2][2] = value;
		upper_line[ci]  = middle_line[ci];
		middle_line[ci] = value;
		if (ci >= 1) begin
			orow = int'(ri) - 1;
			ocol = int'(ci) - 1;
		end else begin
			orow = int'(ri) - 2;
			ocol = int'(w) - 1;
		end
		if (orow >= 0 && orow < int'(h)) begin
			// drop every tap that falls outside the frame
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					yy = orow + r - 1;
					xx = ocol + c - 1;
					p[r][c] = (yy >= 0 && yy < int'(h) && xx >= 0 && xx < int'(w))
						? int'(window_px[r][c]) : 0;
				end
			end
			gx = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
			gy = (p[2][0] + 2 * p[2][1] + p[2][2]) - (p[0][0] + 2 * p[0][1] + p[0][2]);
			frame_end = (orow == int'(h) - 1) && (ocol == int'(w) - 1);
			expected_gradients.push_back('{floor_root(gx * gx + gy * gy), frame_end});
		end
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		// restart after the final word, or once the counters run past the flush point
		if (frame_end || in_row > h + 1) begin
			in_col = 0;
			in_row = 0;
		end
	endfunction

	function automatic void report_mismatch(string field, int want, int got);
		errors++;
		$display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
	endfunction

	// Sender: bursts of random length, separated by random gaps. Long bursts
	// give stretches with no idling at all.
	task automatic send_pixel(input logic [PIX_W-1:0] value);
		if (burst_left == 0) begin
			pixel_ch.valid <= 1'b0;
			repeat (($urandom_range(0, 3) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 4))
				@(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
				: $urandom_range(1, 12);
		end
		burst_left--;
		pixel_ch.valid <= 1'b1;
		pixel_ch.pixel <= value;
		do
			@(posedge clk);
		while (!pixel_ch.ready);
		predict_pixel(value);
		words_sent++;
	endtask

	// Hold the sender until every owed gradient word has arrived, then let a
	// result-less word still in flight drain out.
	task automatic wait_for_idle();
		pixel_ch.valid <= 1'b0;
		while (expected_gradients.size() != 0)
			@(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input cfg_index_t idx, input logic [DIM_W-1:0] value);
		wait_for_idle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_IMAGE_WIDTH)
			width_reg = value;
		else
			height_reg = value;
	endtask

	task automatic set_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		if (w != width_reg)
			write_size(CFG_IMAGE_WIDTH, w);
		if (h != height_reg)
			write_size(CFG_IMAGE_HEIGHT, h);
	endtask

	function automatic logic [PIX_W-1:0] pick_pixel(pixel_style_t style, int x, int y);
		case (style)
			PIX_FULL:     return 8'd255;
			PIX_DIAGONAL: return (x > y) ? 8'd255 : 8'd0;
			PIX_CHECKER:  return ((x + y) % 2 != 0) ? 8'd255 : 8'd0;
			PIX_EXTREME:  return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
			PIX_SMOOTH:   return 8'(100 + 3 * x + $urandom_range(0, 12));
			default:      return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Feed flush words until the counters are back at the top of a frame.
	task automatic flush_home();
		do
			send_pixel(8'($urandom_range(0, 255)));
		while (in_col != 0 || in_row != 0);
	endtask

	task automatic run_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
		input pixel_style_t style);
		int unsigned cols;
		int unsigned rows;
		set_size(w, h);
		cols = clamp_size(width_reg, MAX_WIDTH);
		rows = clamp_size(height_reg, MAX_HEIGHT);
		for (int y = 0; y < int'(rows); y++)
			for (int x = 0; x < int'(cols); x++)
				send_pixel(pick_pixel(style, x, y));
		flush_home();
	endtask

	// At the reset size, fill one full row; then write an all-ones width,
	// which saturates to the same width, and cut the frame to one row. The
	// flush row that closes it leaves every line-store entry written.
	task automatic test_reset_size();
		repeat (WIDTH_RESET) send_pixel(8'($urandom_range(0, 255)));
		write_size(CFG_IMAGE_WIDTH, 2047);
		write_size(CFG_IMAGE_HEIGHT, 1);
		flush_home();
	endtask

	task automatic test_pixel_extremes();
		run_frame(3, 3, PIX_FULL);
		run_frame(3, 3, PIX_DIAGONAL);
	endtask

	// Zero sizes act as 1.
	task automatic test_clamped_sizes();
		run_frame(0, 0, PIX_RANDOM);
		run_frame(0, 3, PIX_EXTREME);
		run_frame(4, 0, PIX_EXTREME);
	endtask

	task automatic test_resize_mid_frame();
		// narrow the width below the column counter: wrap to the next row
		set_size(5, 4);
		repeat (12) send_pixel(8'($urandom_range(0, 255)));
		write_size(CFG_IMAGE_WIDTH, 2);
		flush_home();
		// drop the height below the current row: counters restart with no final word
		set_size(3, 6);
		repeat (13) send_pixel(8'($urandom_range(0, 255)));
		write_size(CFG_IMAGE_HEIGHT, 2);
		flush_home();
		// widen mid-frame
		set_size(3, 3);
		repeat (4) send_pixel(8'($urandom_range(0, 255)));
		write_size(CFG_IMAGE_WIDTH, 6);
		flush_home();
	endtask

	// Mostly complete frames of small random sizes and mixed content; a few
	// wide ones, and some broken frames that resize partway through.
	task automatic test_random_frames();
		int           stop_at;
		int           w;
		int           h;
		pixel_style_t style;
		stop_at = words_sent + RANDOM_WORDS;
		while (words_sent < stop_at) begin
			w = clamp_size(width_reg, MAX_WIDTH);
			h = clamp_size(height_reg, MAX_HEIGHT);
			if ($urandom_range(0, 2) != 0 || w > 400 || h > 10) begin
				if ($urandom_range(0, 24) == 0) begin
					w = $urandom_range(100, 400);
					h = $urandom_range(1, 3);
				end else begin
					w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 24);
					h = $urandom_range(1, 10);
				end
			end
			style = pixel_style_t'($urandom_range(0, 5));
			// pause now and then until the block has delivered everything
			if ($urandom_range(0, 9) == 0)
				wait_for_idle();
			if ($urandom_range(0, 5) == 0) begin
				set_size(DIM_W'(w), DIM_W'(h));
				repeat ($urandom_range(1, w * h)) send_pixel(8'($urandom_range(0, 255)));
				write_size(cfg_index_t'($urandom_range(0, 1)), DIM_W'($urandom_range(0, 30)));
				flush_home();
			end else begin
				run_frame(DIM_W'(w), DIM_W'(h), style);
			end
		end
	endtask

	// Receiver: switch between always ready, coin-flip ready and mostly
	// ready with occasional long stalls.
	initial begin : drive_result_ready
		int mode;
		int span;
		int stall_left;
		result_ch.ready <= 1'b0;
		stall_left = 0;
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(64, 512);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= ($urandom_range(0, 1) != 0);
					default: begin
						if (stall_left > 0) begin
							stall_left--;
							result_ch.ready <= 1'b0;
						end else if ($urandom_range(0, 63) == 0) begin
							stall_left = $urandom_range(10, 40);
							result_ch.ready <= 1'b0;
						end else begin
							result_ch.ready <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	// Compare each accepted gradient word with the oldest one owed.
	always @(posedge clk) begin : check_gradients
		gradient_t want;
		if (result_ch.valid && result_ch.ready) begin
			if (expected_gradients.size() == 0) begin
				errors++;
				$display("%0t ns: gradient_magnitude expected none, actual %0d",
					$time, result_ch.gradient_magnitude);
			end else begin
				want = expected_gradients.pop_front();
				if (result_ch.gradient_magnitude !== want.magnitude)
					report_mismatch("gradient_magnitude", want.magnitude,
						result_ch.gradient_magnitude);
				if (result_ch.frame_last !== want.frame_last)
					report_mismatch("frame_last", want.frame_last, result_ch.frame_last);
			end
		end
	end

	initial begin
		for (int i = 0; i < MAX_WIDTH; i++) begin
			upper_line[i]  = '0;
			middle_line[i] = '0;
		end
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				window_px[r][c] = '0;
		in_col     = 0;
		in_row     = 0;
		width_reg  = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		errors     = 0;
		words_sent = 0;
		burst_left = 0;

		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_index      <= CFG_IMAGE_WIDTH;
		cfg_wdata      <= '0;
		pixel_ch.valid <= 1'b0;
		pixel_ch.pixel <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_size();
		test_pixel_extremes();
		test_clamped_sizes();
		test_resize_mid_frame();
		test_random_frames();

		wait_for_idle();
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
